// ===== rtl/complex_axpbypcz_unit_assert.svh =====
// Assertion macros for the complex AXPBYPCZ unit.
// Used at the end of the top level; needs nothing but the clock and reset names passed in.
`ifndef COMPLEX_AXPBYPCZ_UNIT_ASSERT_SVH
`define COMPLEX_AXPBYPCZ_UNIT_ASSERT_SVH

// same-cycle implication
`define CXA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CXA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cxaxpbypcz_pkg.sv =====
// Shared types and constants of the complex AXPBYPCZ unit.
// No dependencies.
package cxaxpbypcz_pkg;

    localparam int NumRegs   = 6;
    localparam int NumTerms  = 6;
    localparam int AddrWidth = 5;
    localparam int BusWidth  = 32;

    typedef enum logic [2:0] {
        REG_ALPHA_RE = 3'd0,
        REG_ALPHA_IM = 3'd1,
        REG_BETA_RE  = 3'd2,
        REG_BETA_IM  = 3'd3,
        REG_GAMMA_RE = 3'd4,
        REG_GAMMA_IM = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic en_mul;
        logic en_pair;
        logic en_sum;
        logic en_out;
    } t_pipe_ctl;

endpackage

// ===== rtl/cxaxpbypcz_regs.sv =====
// Coefficient register file behind the APB-style configuration port.
// Depends on cxaxpbypcz_pkg.
module cxaxpbypcz_regs
    import cxaxpbypcz_pkg::*;
#(
    parameter int COEF_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [AddrWidth-1:0]         paddr,
    input  logic [BusWidth-1:0]          pwdata,
    output logic [BusWidth-1:0]          prdata,
    output logic                         pready,
    output logic signed [COEF_WIDTH-1:0] o_coef [NumRegs]
);

    localparam logic [COEF_WIDTH-1:0] AlphaReset = COEF_WIDTH'(1) << (COEF_WIDTH - 3);

    logic [COEF_WIDTH-1:0] r_coef [NumRegs];
    logic                  wr_en;
    t_reg_idx              idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[AddrWidth-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[REG_ALPHA_RE] <= AlphaReset;
            r_coef[REG_ALPHA_IM] <= '0;
            r_coef[REG_BETA_RE]  <= '0;
            r_coef[REG_BETA_IM]  <= '0;
            r_coef[REG_GAMMA_RE] <= '0;
            r_coef[REG_GAMMA_IM] <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_ALPHA_RE: r_coef[REG_ALPHA_RE] <= pwdata[COEF_WIDTH-1:0];
                REG_ALPHA_IM: r_coef[REG_ALPHA_IM] <= pwdata[COEF_WIDTH-1:0];
                REG_BETA_RE:  r_coef[REG_BETA_RE]  <= pwdata[COEF_WIDTH-1:0];
                REG_BETA_IM:  r_coef[REG_BETA_IM]  <= pwdata[COEF_WIDTH-1:0];
                REG_GAMMA_RE: r_coef[REG_GAMMA_RE] <= pwdata[COEF_WIDTH-1:0];
                REG_GAMMA_IM: r_coef[REG_GAMMA_IM] <= pwdata[COEF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_ALPHA_RE: prdata = BusWidth'(r_coef[REG_ALPHA_RE]);
            REG_ALPHA_IM: prdata = BusWidth'(r_coef[REG_ALPHA_IM]);
            REG_BETA_RE:  prdata = BusWidth'(r_coef[REG_BETA_RE]);
            REG_BETA_IM:  prdata = BusWidth'(r_coef[REG_BETA_IM]);
            REG_GAMMA_RE: prdata = BusWidth'(r_coef[REG_GAMMA_RE]);
            REG_GAMMA_IM: prdata = BusWidth'(r_coef[REG_GAMMA_IM]);
            default:      prdata = '0;
        endcase
    end

    for (genvar k = 0; k < NumRegs; k++) begin : g_out
        assign o_coef[k] = $signed(r_coef[k]);
    end

endmodule

// ===== rtl/cxaxpbypcz_mul.sv =====
// Multiplier stage: twelve registered coefficient-by-data products.
// Depends on cxaxpbypcz_pkg.
module cxaxpbypcz_mul
    import cxaxpbypcz_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  t_pipe_ctl                               i_ctl,
    input  logic signed [COEF_WIDTH-1:0]            i_coef [NumRegs],
    input  logic signed [DATA_WIDTH-1:0]            i_data [NumTerms],
    output logic signed [DATA_WIDTH+COEF_WIDTH-1:0] o_prod_re [NumTerms],
    output logic signed [DATA_WIDTH+COEF_WIDTH-1:0] o_prod_im [NumTerms]
);

    localparam int ProdWidth = DATA_WIDTH + COEF_WIDTH;

    logic signed [ProdWidth-1:0] r_prod_re [NumTerms];
    logic signed [ProdWidth-1:0] r_prod_im [NumTerms];

    // real term k uses coef k, imaginary term k uses the partner coef (k xor 1)
    for (genvar k = 0; k < NumTerms; k++) begin : g_term
        always_ff @(posedge i_clk) begin
            if (i_ctl.en_mul) begin
                r_prod_re[k] <= ProdWidth'(i_coef[k]) * ProdWidth'(i_data[k]);
                r_prod_im[k] <= ProdWidth'(i_coef[k ^ 1]) * ProdWidth'(i_data[k]);
            end
        end
        assign o_prod_re[k] = r_prod_re[k];
        assign o_prod_im[k] = r_prod_im[k];
    end

endmodule

// ===== rtl/cxaxpbypcz_red.sv =====
// Reduction of six products: pair sums, rounded total, saturation to the data range.
// Depends on cxaxpbypcz_pkg.
module cxaxpbypcz_red
    import cxaxpbypcz_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  t_pipe_ctl                               i_ctl,
    input  logic                                    i_sub_odd,
    input  logic signed [DATA_WIDTH+COEF_WIDTH-1:0] i_prod [NumTerms],
    output logic signed [DATA_WIDTH-1:0]            o_value,
    output logic                                    o_clip
);

    localparam int ProdWidth = DATA_WIDTH + COEF_WIDTH;
    localparam int PairWidth = ProdWidth + 1;
    localparam int SumWidth  = ProdWidth + 3;
    localparam int FracShift = COEF_WIDTH - 3;
    localparam int QWidth    = SumWidth - FracShift;
    localparam int NumPairs  = NumTerms / 2;

    localparam logic signed [SumWidth-1:0]   Half   = SumWidth'(1) << (FracShift - 1);
    localparam logic signed [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [PairWidth-1:0]  r_pair [NumPairs];
    logic signed [QWidth-1:0]     r_q;
    logic signed [DATA_WIDTH-1:0] r_value;
    logic                         r_clip;
    logic signed [SumWidth-1:0]   total;
    logic                         overflow;

    for (genvar j = 0; j < NumPairs; j++) begin : g_pair
        logic signed [PairWidth-1:0] lhs;
        logic signed [PairWidth-1:0] rhs;
        assign lhs = {i_prod[2*j][ProdWidth-1], i_prod[2*j]};
        assign rhs = {i_prod[2*j+1][ProdWidth-1], i_prod[2*j+1]};
        always_ff @(posedge i_clk) begin
            if (i_ctl.en_pair) begin
                r_pair[j] <= i_sub_odd ? (lhs - rhs) : (lhs + rhs);
            end
        end
    end

    // floor((sum + half) / 2^frac): round to nearest, ties towards plus infinity
    assign total = SumWidth'(r_pair[0]) + SumWidth'(r_pair[1]) + SumWidth'(r_pair[2]) + Half;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_q <= total[SumWidth-1:FracShift];
        end
    end

    assign overflow = !((&r_q[QWidth-1:DATA_WIDTH-1]) || !(|r_q[QWidth-1:DATA_WIDTH-1]));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            r_clip  <= overflow;
            r_value <= overflow ? (r_q[QWidth-1] ? MinVal : MaxVal) : r_q[DATA_WIDTH-1:0];
        end
    end

    assign o_value = r_value;
    assign o_clip  = r_clip;

endmodule

// ===== rtl/complex_axpbypcz_unit.sv =====
// Complex AXPBYPCZ unit: z' = alpha*x + beta*y + gamma*z per element, Q1.15 data, Q3.13
// coefficients. Five register stages: input capture, twelve products, pair sums,
// rounded total, saturation. Each stage holds one request and advances whenever the
// stage after it is empty or moving, so one request is taken per clock while i_stall is
// low. A request passes the stages in the order listed and its result is offered from
// the saturation stage. Once all five stages are full the input stall follows the
// output stall in the same cycle. Coefficients sit at byte addresses 0 (alpha_re) to
// 20 (gamma_im) and may be changed only while the pipeline is empty. Depends on
// cxaxpbypcz_pkg, cxaxpbypcz_regs, cxaxpbypcz_mul, cxaxpbypcz_red and
// complex_axpbypcz_unit_assert.svh.
`include "complex_axpbypcz_unit_assert.svh"

module complex_axpbypcz_unit
    import cxaxpbypcz_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [AddrWidth-1:0]         paddr,
    input  logic [BusWidth-1:0]          pwdata,
    output logic [BusWidth-1:0]          prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_x_re,
    input  logic signed [DATA_WIDTH-1:0] i_x_im,
    input  logic signed [DATA_WIDTH-1:0] i_y_re,
    input  logic signed [DATA_WIDTH-1:0] i_y_im,
    input  logic signed [DATA_WIDTH-1:0] i_z_re,
    input  logic signed [DATA_WIDTH-1:0] i_z_im,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_out_re,
    output logic signed [DATA_WIDTH-1:0] o_out_im,
    output logic                         o_saturated
);

    localparam int NumStages = 5;
    localparam int ProdWidth = DATA_WIDTH + COEF_WIDTH;

    localparam logic signed [DATA_WIDTH-1:0] SatMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SatMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [NumStages-1:0]         r_vld;
    logic [NumStages-1:0]         n_vld;
    logic [NumStages:0]           ready;
    logic signed [DATA_WIDTH-1:0] r_data [NumTerms];
    logic signed [COEF_WIDTH-1:0] coef [NumRegs];
    logic signed [ProdWidth-1:0]  prod_re [NumTerms];
    logic signed [ProdWidth-1:0]  prod_im [NumTerms];
    logic                         clip_re;
    logic                         clip_im;
    t_pipe_ctl                    ctl;
    logic                         take_in;
    logic                         on_rail;

    // a stage may load when it is empty or its contents move on
    assign ready[NumStages] = !i_stall;
    for (genvar s = 0; s < NumStages; s++) begin : g_ready
        assign ready[s] = !r_vld[s] || ready[s+1];
    end

    always_comb begin
        n_vld = r_vld;
        if (ready[0]) begin
            n_vld[0] = i_valid;
        end
        for (int s = 1; s < NumStages; s++) begin
            if (ready[s]) begin
                n_vld[s] = r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            r_data[0] <= i_x_re;
            r_data[1] <= i_x_im;
            r_data[2] <= i_y_re;
            r_data[3] <= i_y_im;
            r_data[4] <= i_z_re;
            r_data[5] <= i_z_im;
        end
    end

    assign ctl.en_mul  = ready[1];
    assign ctl.en_pair = ready[2];
    assign ctl.en_sum  = ready[3];
    assign ctl.en_out  = ready[4];

    cxaxpbypcz_regs #(
        .COEF_WIDTH(COEF_WIDTH)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (coef)
    );

    cxaxpbypcz_mul #(
        .DATA_WIDTH(DATA_WIDTH),
        .COEF_WIDTH(COEF_WIDTH)
    ) u_mul (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_coef    (coef),
        .i_data    (r_data),
        .o_prod_re (prod_re),
        .o_prod_im (prod_im)
    );

    cxaxpbypcz_red #(
        .DATA_WIDTH(DATA_WIDTH),
        .COEF_WIDTH(COEF_WIDTH)
    ) u_red_re (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_sub_odd (1'b1),
        .i_prod    (prod_re),
        .o_value   (o_out_re),
        .o_clip    (clip_re)
    );

    cxaxpbypcz_red #(
        .DATA_WIDTH(DATA_WIDTH),
        .COEF_WIDTH(COEF_WIDTH)
    ) u_red_im (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_sub_odd (1'b0),
        .i_prod    (prod_im),
        .o_value   (o_out_im),
        .o_clip    (clip_im)
    );

    assign o_valid     = r_vld[NumStages-1];
    assign o_stall     = !ready[0];
    assign o_saturated = clip_re || clip_im;

    assign take_in = i_valid && !o_stall;
    assign on_rail = (o_out_re == SatMax) || (o_out_re == SatMin) ||
                     (o_out_im == SatMax) || (o_out_im == SatMin);

    `CXA_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, &r_vld, "stall with a stage empty")
    `CXA_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, take_in, r_vld[0], "request lost at entry")
    `CXA_ASSERT_NOW(a_sat_rail, i_clk, i_rst_n, o_valid && o_saturated, on_rail, "clip off rail")

endmodule

// ===== verif/cxa_scoreboard_pkg.sv =====
// Scoreboard for the complex AXPBYPCZ unit testbench: request and result types, the
// coefficient copy, the fixed-point predictor of z' and the queue of expected results.
// Depends on cxaxpbypcz_pkg.
package cxa_scoreboard_pkg;
    import cxaxpbypcz_pkg::*;

    localparam int DataWidth = 16;
    localparam int CoefWidth = 16;
    localparam int FracShift = CoefWidth - 3;
    localparam longint MaxData = (longint'(1) << (DataWidth - 1)) - 1;
    localparam longint MinData = -MaxData - 1;
    localparam longint MaxCoef = (longint'(1) << (CoefWidth - 1)) - 1;
    localparam longint MinCoef = -MaxCoef - 1;
    localparam longint CoefOne = longint'(1) << FracShift;
    localparam int MaxReports = 200;

    typedef logic signed [DataWidth-1:0] t_sample;
    typedef logic signed [CoefWidth-1:0] t_coef;

    typedef struct packed {
        t_sample x_re;
        t_sample x_im;
        t_sample y_re;
        t_sample y_im;
        t_sample z_re;
        t_sample z_im;
    } t_z_request;

    typedef struct packed {
        t_sample re;
        t_sample im;
        logic    sat;
    } t_z_result;

    class cxa_scoreboard;
        t_coef     coef [NumRegs];
        t_z_result expected_z [$];
        int        errors;

        function new();
            foreach (coef[i]) coef[i] = '0;
            coef[REG_ALPHA_RE] = t_coef'(CoefOne);
            errors = 0;
        endfunction

        // out-of-range indexes are dropped, bits above the coefficient width ignored
        function void set_coef(int idx, logic [BusWidth-1:0] value);
            if (idx >= 0 && idx < NumRegs) coef[idx] = value[CoefWidth-1:0];
        endfunction

        // round half towards plus infinity, then clip to the data range
        function t_sample round_sat(longint acc, inout logic clip);
            longint q;
            q = (acc + (longint'(1) << (FracShift - 1))) >>> FracShift;
            if (q > MaxData) begin
                q = MaxData;
                clip = 1'b1;
            end else if (q < MinData) begin
                q = MinData;
                clip = 1'b1;
            end
            return t_sample'(q);
        endfunction

        function t_z_result predict_z(t_z_request r);
            longint ar, ai, br, bi, gr, gi;
            longint xr, xi, yr, yi, zr, zi;
            longint acc_re, acc_im;
            logic clip;
            t_z_result res;
            ar = longint'($signed(coef[REG_ALPHA_RE]));
            ai = longint'($signed(coef[REG_ALPHA_IM]));
            br = longint'($signed(coef[REG_BETA_RE]));
            bi = longint'($signed(coef[REG_BETA_IM]));
            gr = longint'($signed(coef[REG_GAMMA_RE]));
            gi = longint'($signed(coef[REG_GAMMA_IM]));
            xr = longint'($signed(r.x_re));
            xi = longint'($signed(r.x_im));
            yr = longint'($signed(r.y_re));
            yi = longint'($signed(r.y_im));
            zr = longint'($signed(r.z_re));
            zi = longint'($signed(r.z_im));
            acc_re = ar * xr - ai * xi + br * yr - bi * yi + gr * zr - gi * zi;
            acc_im = ai * xr + ar * xi + bi * yr + br * yi + gi * zr + gr * zi;
            clip = 1'b0;
            res.re = round_sat(acc_re, clip);
            res.im = round_sat(acc_im, clip);
            res.sat = clip;
            return res;
        endfunction

        task report(string msg);
            if (errors < MaxReports) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void note_request(t_z_request r);
            expected_z.push_back(predict_z(r));
        endfunction

        task check_result(t_z_result got);
            t_z_result want;
            if (expected_z.size() == 0) begin
                report($sformatf("result re=%0d im=%0d with no request outstanding",
                                 $signed(got.re), $signed(got.im)));
                return;
            end
            want = expected_z.pop_front();
            if (got.re !== want.re)
                report($sformatf("out_re got %0d want %0d", $signed(got.re), $signed(want.re)));
            if (got.im !== want.im)
                report($sformatf("out_im got %0d want %0d", $signed(got.im), $signed(want.im)));
            if (got.sat !== want.sat)
                report($sformatf("saturated got %0b want %0b", got.sat, want.sat));
        endtask

        function int pending();
            return expected_z.size();
        endfunction
    endclass

endpackage

// ===== verif/complex_axpbypcz_unit_tb.sv =====
// Testbench top for complex_axpbypcz_unit: directed and random requests over several
// coefficient sets, random idling on both sides, checked against cxa_scoreboard.
// Depends on cxaxpbypcz_pkg, cxa_scoreboard_pkg and the unit RTL.
module complex_axpbypcz_unit_tb
    import cxaxpbypcz_pkg::*;
    import cxa_scoreboard_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit  = 1000;
    localparam int LongHold    = 80;
    localparam int DrainCycles = 10;
    localparam int RandPhases  = 10;
    localparam int PhaseItems  = 95;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [AddrWidth-1:0] paddr   = '0;
    logic [BusWidth-1:0]  pwdata  = '0;
    logic [BusWidth-1:0]  prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_sample              i_x_re  = '0;
    t_sample              i_x_im  = '0;
    t_sample              i_y_re  = '0;
    t_sample              i_y_im  = '0;
    t_sample              i_z_re  = '0;
    t_sample              i_z_im  = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_sample              o_out_re;
    t_sample              o_out_im;
    logic                 o_saturated;

    cxa_scoreboard sb = new();

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    complex_axpbypcz_unit #(
        .DATA_WIDTH(DataWidth),
        .COEF_WIDTH(CoefWidth)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_re     (i_x_re),
        .i_x_im     (i_x_im),
        .i_y_re     (i_y_re),
        .i_y_im     (i_y_im),
        .i_z_re     (i_z_re),
        .i_z_im     (i_z_im),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_re   (o_out_re),
        .o_out_im   (o_out_im),
        .o_saturated(o_saturated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_z_request req;
        t_z_result  res;
        logic       busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (i_valid && !o_stall) begin
                req = {i_x_re, i_x_im, i_y_re, i_y_im, i_z_re, i_z_im};
                sb.note_request(req);
                busy = 1'b1;
            end
            if (o_valid && !i_stall) begin
                res = {o_out_re, o_out_im, o_saturated};
                sb.check_result(res);
                busy = 1'b1;
            end
            if (psel && penable && pwrite && pready) busy = 1'b1;
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < StallLimit) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic apb_write(logic [AddrWidth-1:0] addr, logic [BusWidth-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper bus bits carry junk; the unit must ignore them
    task automatic write_coef(int idx, t_coef value);
        logic [BusWidth-1:0] data;
        data = {(BusWidth - CoefWidth)'($urandom), value};
        apb_write(AddrWidth'(4 * idx), data);
        sb.set_coef(idx, data);
    endtask

    task automatic set_coefs(longint ar, longint ai, longint br, longint bi,
                             longint gr, longint gi);
        write_coef(REG_ALPHA_RE, t_coef'(ar));
        write_coef(REG_ALPHA_IM, t_coef'(ai));
        write_coef(REG_BETA_RE, t_coef'(br));
        write_coef(REG_BETA_IM, t_coef'(bi));
        write_coef(REG_GAMMA_RE, t_coef'(gr));
        write_coef(REG_GAMMA_IM, t_coef'(gi));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic send(t_z_request r);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_x_re, i_x_im, i_y_re, i_y_im, i_z_re, i_z_im} <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic t_z_request req_of(longint xr, longint xi, longint yr,
                                          longint yi, longint zr, longint zi);
        return {t_sample'(xr), t_sample'(xi), t_sample'(yr),
                t_sample'(yi), t_sample'(zr), t_sample'(zi)};
    endfunction

    function automatic t_sample rand_sample();
        unique case ($urandom_range(0, 7))
            0: return t_sample'(MinData);
            1: return t_sample'(MaxData);
            2: return '0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_coef pick_coef();
        unique case ($urandom_range(0, 9))
            0: return t_coef'(MinCoef);
            1: return t_coef'(MaxCoef);
            2: return '0;
            3: return t_coef'(CoefOne);
            4: return t_coef'(-CoefOne);
            default: return t_coef'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        t_coef cv [NumRegs];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coefficients from reset: alpha = 1.0, the rest zero
        send(req_of(0, 0, 0, 0, 0, 0));
        send(req_of(MaxData, MaxData, MaxData, MaxData, MaxData, MaxData));
        send(req_of(MinData, MinData, MinData, MinData, MinData, MinData));
        send(req_of(MaxData, MinData, MinData, MaxData, 1, -1));
        send(req_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send(req_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        drain();

        // most negative coefficients, plus writes to unmapped addresses
        set_coefs(MinCoef, MinCoef, MinCoef, MinCoef, MinCoef, MinCoef);
        write_coef(NumRegs, pick_coef());
        write_coef(NumRegs + 1, pick_coef());
        send(req_of(MinData, MinData, MinData, MinData, MinData, MinData));
        send(req_of(MaxData, MaxData, MaxData, MaxData, MaxData, MaxData));
        send(req_of(MaxData, MinData, MaxData, MinData, MaxData, MinData));
        send(req_of(0, 0, 0, 0, 0, 0));
        drain();

        set_coefs(MaxCoef, MaxCoef, MaxCoef, MaxCoef, MaxCoef, MaxCoef);
        send(req_of(MaxData, MaxData, MaxData, MaxData, MaxData, MaxData));
        send(req_of(MinData, MinData, MinData, MinData, MinData, MinData));
        send(req_of(MinData, MaxData, MaxData, MinData, MinData, MaxData));
        drain();

        // smallest alpha: exact halves and near-halves of the rounding
        set_coefs(1, 0, 0, 0, 0, 0);
        send(req_of(4096, -4096, MaxData, MinData, MaxData, MinData));
        send(req_of(-4096, 4096, 0, 0, 0, 0));
        send(req_of(4095, -4097, 0, 0, 0, 0));
        send(req_of(12288, -12288, 0, 0, 0, 0));
        send(req_of(-4097, 4095, 0, 0, 0, 0));
        drain();

        for (int p = 0; p < RandPhases; p++) begin
            foreach (cv[i]) cv[i] = pick_coef();
            unique case (p % 4)
                0: begin
                    cv[REG_BETA_RE]  = t_coef'(CoefOne);
                    cv[REG_BETA_IM]  = '0;
                    cv[REG_GAMMA_RE] = '0;
                    cv[REG_GAMMA_IM] = '0;
                end
                1: begin
                    cv[REG_GAMMA_RE] = '0;
                    cv[REG_GAMMA_IM] = '0;
                end
                2: begin
                    cv[REG_BETA_RE]  = '0;
                    cv[REG_BETA_IM]  = '0;
                    cv[REG_GAMMA_RE] = t_coef'(CoefOne);
                    cv[REG_GAMMA_IM] = '0;
                end
                default: ;
            endcase
            set_coefs(cv[REG_ALPHA_RE], cv[REG_ALPHA_IM], cv[REG_BETA_RE],
                      cv[REG_BETA_IM], cv[REG_GAMMA_RE], cv[REG_GAMMA_IM]);

            if (p < 4) begin
                snd_idle_pct = 33;
                rcv_idle_pct = 45;
            end else if (p < 7) begin
                snd_idle_pct = 45;
                rcv_idle_pct = 33;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            // back-pressure: result side holds off while requests keep coming
            if (p == 8) hold_left = LongHold;

            for (int n = 0; n < PhaseItems; n++) begin
                if (p == 5 && n == PhaseItems / 2) drain();
                send(req_of(rand_sample(), rand_sample(), rand_sample(),
                            rand_sample(), rand_sample(), rand_sample()));
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
